// ----- src/mi3_pkg.sv -----
// ----------------------------------------------------------------------------
// mi3_pkg: shared types and constants for the 3x3 matrix inverse core
// Field widths, item structs, and the cofactor index tables.
// ----------------------------------------------------------------------------
`default_nettype none

package mi3_pkg;

    localparam int FRAC_BITS = 16;

    localparam int EW  = 32;               // element width
    localparam int CW  = 2 * EW;           // signed cofactor width
    localparam int MW  = CW - 1;           // cofactor magnitude width
    localparam int TW  = EW + MW;          // determinant term magnitude width
    localparam int DW  = TW + 3;           // signed determinant width
    localparam int DMW = DW - 1;           // determinant magnitude width
    localparam int QW  = EW + 1;           // quotient bits produced
    localparam int NW  = MW + 2 * FRAC_BITS; // dividend width

    typedef logic signed [EW-1:0]  elem_t;
    typedef logic signed [CW-1:0]  cof_t;
    typedef logic signed [DW-1:0]  det_t;
    typedef logic [MW-1:0]         cmag_t;
    typedef logic [DMW-1:0]        dmag_t;

    typedef struct packed {
        logic signed [EW-1:0] a00;
        logic signed [EW-1:0] a01;
        logic signed [EW-1:0] a02;
        logic signed [EW-1:0] a10;
        logic signed [EW-1:0] a11;
        logic signed [EW-1:0] a12;
        logic signed [EW-1:0] a20;
        logic signed [EW-1:0] a21;
        logic signed [EW-1:0] a22;
    } mat_in_t;

    typedef struct packed {
        logic signed [EW-1:0] inv00;
        logic signed [EW-1:0] inv01;
        logic signed [EW-1:0] inv02;
        logic signed [EW-1:0] inv10;
        logic signed [EW-1:0] inv11;
        logic signed [EW-1:0] inv12;
        logic signed [EW-1:0] inv20;
        logic signed [EW-1:0] inv21;
        logic signed [EW-1:0] inv22;
        logic                 singular;
        logic                 clipped;
    } mat_out_t;

    // Adjugate entry k is +/-(a[X]*a[Y] - a[Z]*a[W]), elements in row-major order.
    localparam int PX [9] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
    localparam int PY [9] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
    localparam int PZ [9] = '{7, 7, 4, 6, 6, 3, 6, 6, 3};
    localparam int PW [9] = '{5, 2, 2, 5, 2, 2, 4, 1, 1};
    localparam logic [8:0] COF_NEG = 9'b010101010;

    localparam logic [EW-1:0] SAT_POS = {1'b0, {(EW-1){1'b1}}};
    localparam logic [EW-1:0] SAT_NEG = {1'b1, {(EW-1){1'b0}}};

endpackage

`default_nettype wire

// ----- src/mi3_cofactor.sv -----
// ----------------------------------------------------------------------------
// mi3_cofactor: adjugate entries of the input matrix
// Registers the item, forms the eighteen products, then the nine signed
// cofactors. Column 0 travels along for the determinant.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_cofactor
    import mi3_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    en,
    input  wire logic    in_v,
    input  wire mat_in_t in_d,
    output logic         out_v,
    output cof_t         cof [9],
    output elem_t        col0 [3]
);

    logic  v1_reg, v2_reg, v3_reg;
    elem_t a_reg [9];
    cof_t  pxy_reg [9];
    cof_t  pzw_reg [9];
    elem_t c2_reg [3];
    cof_t  cof_reg [9];
    elem_t c3_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_v;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg[0] <= in_d.a00;
            a_reg[1] <= in_d.a01;
            a_reg[2] <= in_d.a02;
            a_reg[3] <= in_d.a10;
            a_reg[4] <= in_d.a11;
            a_reg[5] <= in_d.a12;
            a_reg[6] <= in_d.a20;
            a_reg[7] <= in_d.a21;
            a_reg[8] <= in_d.a22;
            for (int k = 0; k < 9; k++)
            begin
                pxy_reg[k] <= a_reg[PX[k]] * a_reg[PY[k]];
                pzw_reg[k] <= a_reg[PZ[k]] * a_reg[PW[k]];
                cof_reg[k] <= COF_NEG[k] ? (pzw_reg[k] - pxy_reg[k])
                                         : (pxy_reg[k] - pzw_reg[k]);
            end
            for (int i = 0; i < 3; i++)
            begin
                c2_reg[i] <= a_reg[3 * i];
                c3_reg[i] <= c2_reg[i];
            end
        end
    end

    assign out_v = v3_reg;
    assign cof   = cof_reg;
    assign col0  = c3_reg;

endmodule

`default_nettype wire

// ----- src/mi3_det.sv -----
// ----------------------------------------------------------------------------
// mi3_det: determinant by expansion down column 0
// Split 32 x 63 products, signed terms, a three-way sum, then magnitudes and
// the sign of every quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_det
    import mi3_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire logic  in_v,
    input  wire cof_t  cof [9],
    input  wire elem_t col0 [3],
    output logic       out_v,
    output dmag_t      dmag,
    output logic       sing,
    output logic [8:0] sneg,
    output cmag_t      mmag [9]
);

    logic              v4_reg, v5_reg, v6_reg, v7_reg;
    logic [CW-1:0]     pl_reg [3];
    logic [CW-2:0]     ph_reg [3];
    logic [2:0]        tneg_reg;
    det_t              term_reg [3];
    det_t              det_reg;
    cof_t              c4_reg [9];
    cof_t              c5_reg [9];
    cof_t              c6_reg [9];
    dmag_t             dmag_reg;
    logic              sing_reg;
    logic [8:0]        sneg_reg;
    cmag_t             mmag_reg [9];

    logic [EW-1:0]     emag [3];
    cmag_t             cmag [3];
    logic [TW-1:0]     tsum [3];
    logic              dneg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            emag[i] = col0[i][EW-1] ? EW'(-col0[i]) : col0[i];
            cmag[i] = cof[i][CW-1] ? MW'(-cof[i]) : cof[i][MW-1:0];
            tsum[i] = {ph_reg[i], {EW{1'b0}}} + TW'(pl_reg[i]);
        end
        dneg = det_reg[DW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= in_v;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pl_reg[i]   <= emag[i] * cmag[i][EW-1:0];
                ph_reg[i]   <= emag[i] * cmag[i][MW-1:EW];
                tneg_reg[i] <= col0[i][EW-1] ^ cof[i][CW-1];
                term_reg[i] <= tneg_reg[i] ? -det_t'(tsum[i]) : det_t'(tsum[i]);
            end
            det_reg <= term_reg[0] + term_reg[1] + term_reg[2];
            c4_reg  <= cof;
            c5_reg  <= c4_reg;
            c6_reg  <= c5_reg;

            dmag_reg <= dneg ? DMW'(-det_reg) : det_reg[DMW-1:0];
            sing_reg <= (det_reg == '0);
            for (int k = 0; k < 9; k++)
            begin
                sneg_reg[k] <= c6_reg[k][CW-1] ^ dneg;
                mmag_reg[k] <= c6_reg[k][CW-1] ? MW'(-c6_reg[k]) : c6_reg[k][MW-1:0];
            end
        end
    end

    assign out_v = v7_reg;
    assign dmag  = dmag_reg;
    assign sing  = sing_reg;
    assign sneg  = sneg_reg;
    assign mmag  = mmag_reg;

endmodule

`default_nettype wire

// ----- src/mi3_divider.sv -----
// ----------------------------------------------------------------------------
// mi3_divider: nine pipelined restoring dividers and saturation
// One quotient bit per stage in each lane, with the divisor shared along a
// single register line, then rounding toward zero and clipping to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_divider
    import mi3_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic       in_v,
    input  wire dmag_t      dmag,
    input  wire logic       sing,
    input  wire logic [8:0] sneg,
    input  wire cmag_t      mmag [9],
    output logic            out_v,
    output mat_out_t        out_d
);

    logic [DMW-1:0] rem_reg  [QW+1][9];
    logic [QW-1:0]  nb_reg   [QW+1][9];
    logic [8:0]     ovf_reg  [QW+1];
    logic [8:0]     sneg_reg [QW+1];
    dmag_t          dmag_reg [QW+1];
    logic           sing_reg [QW+1];
    logic           v_reg    [QW+1];
    logic           fv_reg;
    mat_out_t       fd_reg;

    logic [NW-1:0]  num [9];

    // Entry stage: the top of the dividend either already reaches the divisor
    // (quotient of 2^33 or more) or seeds the partial remainder.
    always_comb
    begin
        for (int k = 0; k < 9; k++)
            num[k] = NW'(mmag[k]) << (2 * FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 9; k++)
            begin
                rem_reg[0][k] <= DMW'(num[k][NW-1:QW]);
                nb_reg[0][k]  <= num[k][QW-1:0];
                ovf_reg[0][k] <= (DMW'(num[k][NW-1:QW]) >= dmag);
            end
            sneg_reg[0] <= sneg;
            dmag_reg[0] <= dmag;
            sing_reg[0] <= sing;
        end
    end

    for (genvar j = 1; j <= QW; j++)
    begin : g_step
        logic [DMW:0] trial [9];
        logic [DMW:0] diff  [9];
        logic [8:0]   ge;

        always_comb
        begin
            for (int k = 0; k < 9; k++)
            begin
                trial[k] = {rem_reg[j-1][k], nb_reg[j-1][k][QW-1]};
                diff[k]  = trial[k] - {1'b0, dmag_reg[j-1]};
                ge[k]    = (trial[k] >= {1'b0, dmag_reg[j-1]});
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else if (en)
                v_reg[j] <= v_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int k = 0; k < 9; k++)
                begin
                    rem_reg[j][k] <= ge[k] ? diff[k][DMW-1:0] : trial[k][DMW-1:0];
                    nb_reg[j][k]  <= {nb_reg[j-1][k][QW-2:0], ge[k]};
                end
                ovf_reg[j]  <= ovf_reg[j-1];
                sneg_reg[j] <= sneg_reg[j-1];
                dmag_reg[j] <= dmag_reg[j-1];
                sing_reg[j] <= sing_reg[j-1];
            end
        end
    end

    // Saturation. A negative result may reach -2^31 exactly without clipping.
    logic [EW-1:0] val [9];
    logic [8:0]    clip;
    mat_out_t      fd_next;

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            if (sneg_reg[QW][k])
            begin
                clip[k] = ovf_reg[QW][k] || (nb_reg[QW][k] > QW'(SAT_NEG));
                val[k]  = clip[k] ? SAT_NEG : EW'(-nb_reg[QW][k]);
            end
            else
            begin
                clip[k] = ovf_reg[QW][k] || (nb_reg[QW][k][QW-1:EW-1] != '0);
                val[k]  = clip[k] ? SAT_POS : nb_reg[QW][k][EW-1:0];
            end
            if (sing_reg[QW])
            begin
                clip[k] = 1'b0;
                val[k]  = '0;
            end
        end
        fd_next.inv00    = val[0];
        fd_next.inv01    = val[1];
        fd_next.inv02    = val[2];
        fd_next.inv10    = val[3];
        fd_next.inv11    = val[4];
        fd_next.inv12    = val[5];
        fd_next.inv20    = val[6];
        fd_next.inv21    = val[7];
        fd_next.inv22    = val[8];
        fd_next.singular = sing_reg[QW];
        fd_next.clipped  = |clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= 1'b0;
        else if (en)
            fv_reg <= v_reg[QW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            fd_reg <= fd_next;
    end

    assign out_v = fv_reg;
    assign out_d = fd_reg;

endmodule

`default_nettype wire

// ----- src/matrix3_inverse_core.sv -----
// ----------------------------------------------------------------------------
// matrix3_inverse_core: pipelined 3x3 Q16.16 matrix inverse, one item per
// cycle while req_stall is low. Most of the pipeline is the 33 one-bit stages
// of the nine dividers. Reset is asynchronous and clears only valid state; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix3_inverse_core
    import mi3_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire mat_in_t  req,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output mat_out_t      rsp
);

    logic       en;
    logic       c_v;
    cof_t       c_cof [9];
    elem_t      c_col0 [3];
    logic       d_v;
    dmag_t      d_dmag;
    logic       d_sing;
    logic [8:0] d_sneg;
    cmag_t      d_mmag [9];
    logic       p_v;
    mat_out_t   p_d;

    logic       out_v_reg, sk_v_reg;
    mat_out_t   out_d_reg, sk_d_reg;
    logic       take, push;

    // The pipeline moves as one; it halts only when the skid entry is full.
    assign en   = !sk_v_reg;
    assign take = out_v_reg && !rsp_stall;
    assign push = en && p_v;

    mi3_cofactor u_cof (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .in_v  (req_valid),
        .in_d  (req),
        .out_v (c_v),
        .cof   (c_cof),
        .col0  (c_col0)
    );

    mi3_det u_det (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .in_v  (c_v),
        .cof   (c_cof),
        .col0  (c_col0),
        .out_v (d_v),
        .dmag  (d_dmag),
        .sing  (d_sing),
        .sneg  (d_sneg),
        .mmag  (d_mmag)
    );

    mi3_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .in_v  (d_v),
        .dmag  (d_dmag),
        .sing  (d_sing),
        .sneg  (d_sneg),
        .mmag  (d_mmag),
        .out_v (p_v),
        .out_d (p_d)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
            sk_v_reg  <= 1'b0;
        end
        else if (push)
        begin
            if (!out_v_reg || take)
                out_v_reg <= 1'b1;
            else
                sk_v_reg <= 1'b1;
        end
        else if (take)
        begin
            out_v_reg <= sk_v_reg;
            sk_v_reg  <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            if (!out_v_reg || take)
                out_d_reg <= p_d;
            else
                sk_d_reg <= p_d;
        end
        else if (take && sk_v_reg)
            out_d_reg <= sk_d_reg;
    end

    assign req_stall = sk_v_reg;
    assign rsp_valid = out_v_reg;
    assign rsp       = out_d_reg;

endmodule

`default_nettype wire
